// ===== rtl/core/ctm_pkg.sv =====
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and constants of the cassette tape modem
// Event codes, register indexes, timing constants and the item, result and
// configuration structs used across the modem modules.
// ----------------------------------------------------------------------------
package ctm_pkg;

	// Tape clock and multiples used by the sample-rate accumulator
	localparam logic [21:0] TAPE_CLK_1 = 22'd1193182;
	localparam logic [21:0] TAPE_CLK_2 = 22'd2386364;
	localparam logic [21:0] TAPE_CLK_3 = 22'd3579546;

	// Load half-periods, in tape clocks
	localparam logic [9:0] HALF_ONE  = 10'd596;
	localparam logic [9:0] HALF_ZERO = 10'd298;

	// Save edge-gap thresholds, in tape clocks
	localparam logic [31:0] GAP_MIN  = 32'd298;
	localparam logic [31:0] GAP_ZERO = 32'd894;
	localparam logic [31:0] GAP_ONE  = 32'd1491;

	// Event codes
	localparam logic [1:0] ACT_TICKS = 2'd0;
	localparam logic [1:0] ACT_LEVEL = 2'd1;
	localparam logic [1:0] ACT_MOTOR = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PCM_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_VOLUME    = 3'd4;

	localparam logic [16:0] RATE_RESET   = 17'd44100;
	localparam logic [6:0]  VOLUME_RESET = 7'd64;

	typedef struct packed {
		logic        save_mode;
		logic        pcm_mode;
		logic [16:0] sample_rate;
		logic        write_protect;
		logic [6:0]  out_volume;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] tick_count;
		logic       level;
		logic [7:0] tape_byte;
		logic       tape_byte_ok;
	} item_t;

	typedef struct packed {
		logic       input_level;
		logic       byte_taken;
		logic       write_valid;
		logic [7:0] write_byte;
	} result_t;

endpackage

// ===== rtl/core/ctm_rate.sv =====
// ----------------------------------------------------------------------------
// ctm_rate: PCM sample-instant accumulator
// Adds rate times ticks to the running remainder, flags a sample instant and
// reduces the sum modulo the tape clock by compare and subtract.
// ----------------------------------------------------------------------------
module ctm_rate
	import ctm_pkg::*;
(
	input  logic [16:0] sample_rate,
	input  logic [3:0]  tick_count,
	input  logic [20:0] remainder,
	output logic [20:0] remainder_next,
	output logic        hit
);

	logic [20:0] product;
	logic [21:0] total;
	logic [21:0] reduced;

	assign product = sample_rate * tick_count;
	assign total   = {1'b0, product} + {1'b0, remainder};

	always_comb begin
		if (total >= TAPE_CLK_3) begin
			reduced = total - TAPE_CLK_3;
		end else if (total >= TAPE_CLK_2) begin
			reduced = total - TAPE_CLK_2;
		end else if (total >= TAPE_CLK_1) begin
			reduced = total - TAPE_CLK_1;
		end else begin
			reduced = total;
		end
	end

	assign remainder_next = reduced[20:0];
	assign hit            = (total >= TAPE_CLK_1);

endmodule

// ===== rtl/core/ctm_engine.sv =====
// ----------------------------------------------------------------------------
// ctm_engine: modem state and per-event update
// Holds the tape state and computes the next state and the result of one
// event in a single pass.
// ----------------------------------------------------------------------------
module ctm_engine
	import ctm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    clear,
	input  cfg_t    cfg,
	input  item_t   item,
	output result_t res
);

	logic [31:0] clock_count_q, clock_count_d;
	logic [31:0] last_edge_q, last_edge_d;
	logic [9:0]  half_left_q, half_left_d;
	logic [20:0] rate_rem_q, rate_rem_d;
	logic        motor_q, motor_d;
	logic        out_level_q, out_level_d;
	logic        in_level_q, in_level_d;
	logic [7:0]  pcm_drive_q, pcm_drive_d;
	logic [2:0]  pack_count_q, pack_count_d;
	logic [7:0]  pack_bits_q, pack_bits_d;
	logic [3:0]  unpack_count_q, unpack_count_d;
	logic [7:0]  unpack_bits_q, unpack_bits_d;
	logic        cur_bit_q, cur_bit_d;
	logic [7:0]  tap_a_q, tap_a_d;
	logic [7:0]  tap_b_q, tap_b_d;

	logic [20:0] rem_next;
	logic        rate_hit;
	logic [31:0] gap;
	logic [10:0] smooth_sum;
	logic        smooth_neg;
	logic [3:0]  rest;
	logic [7:0]  merged_bits;

	ctm_rate u_rate (
		.sample_rate    (cfg.sample_rate),
		.tick_count     (item.tick_count),
		.remainder      (rate_rem_q),
		.remainder_next (rem_next),
		.hit            (rate_hit)
	);

	assign gap        = clock_count_q - last_edge_q;
	assign smooth_sum = {{3{tap_a_q[7]}}, tap_a_q} + {{2{tap_b_q[7]}}, tap_b_q, 1'b0}
		+ {{3{item.tape_byte[7]}}, item.tape_byte};
	// quotient by four truncated toward zero is negative only from -4 down
	assign smooth_neg  = ($signed(smooth_sum) < -11'sd3);
	assign rest        = item.tick_count - half_left_q[3:0];
	assign merged_bits = pack_bits_q
		| ((gap >= GAP_ZERO && !cfg.write_protect) ? (8'h80 >> pack_count_q) : 8'h00);

	always_comb begin
		logic next_bit;
		logic motor_clear;
		next_bit       = cur_bit_q;
		motor_clear    = 1'b0;
		clock_count_d  = clock_count_q;
		last_edge_d    = last_edge_q;
		half_left_d    = half_left_q;
		rate_rem_d     = rate_rem_q;
		motor_d        = motor_q;
		out_level_d    = out_level_q;
		in_level_d     = in_level_q;
		pcm_drive_d    = pcm_drive_q;
		pack_count_d   = pack_count_q;
		pack_bits_d    = pack_bits_q;
		unpack_count_d = unpack_count_q;
		unpack_bits_d  = unpack_bits_q;
		cur_bit_d      = cur_bit_q;
		tap_a_d        = tap_a_q;
		tap_b_d        = tap_b_q;
		res            = '0;

		case (item.action)
			ACT_TICKS: begin
				clock_count_d = clock_count_q + {28'd0, item.tick_count};
				if (motor_q && cfg.pcm_mode) begin
					rate_rem_d = rem_next;
					if (rate_hit) begin
						if (cfg.save_mode) begin
							if (!cfg.write_protect) begin
								res.write_valid = 1'b1;
								res.write_byte  = pcm_drive_q;
							end
						end else if (item.tape_byte_ok) begin
							res.byte_taken = 1'b1;
							tap_a_d        = tap_b_q;
							tap_b_d        = item.tape_byte;
							in_level_d     = !smooth_neg;
						end else begin
							in_level_d = 1'b1;
						end
					end
				end else if (motor_q && !cfg.save_mode) begin
					if (half_left_q > {6'd0, item.tick_count}) begin
						half_left_d = half_left_q - {6'd0, item.tick_count};
					end else begin
						in_level_d = ~in_level_q;
						// fetch the next bit on the rising half
						if (!in_level_q) begin
							if (unpack_count_q == 4'd0) begin
								if (item.tape_byte_ok) begin
									res.byte_taken = 1'b1;
									next_bit       = item.tape_byte[7];
									unpack_bits_d  = {item.tape_byte[6:0], 1'b0};
									unpack_count_d = 4'd7;
								end
							end else begin
								next_bit       = unpack_bits_q[7];
								unpack_bits_d  = {unpack_bits_q[6:0], 1'b0};
								unpack_count_d = unpack_count_q - 4'd1;
							end
						end
						cur_bit_d   = next_bit;
						half_left_d = (next_bit ? HALF_ONE : HALF_ZERO) - {6'd0, rest};
					end
				end
			end
			ACT_LEVEL: begin
				if (!motor_q) begin
					in_level_d = item.level;
				end else if (out_level_q != item.level) begin
					out_level_d = item.level;
					if (cfg.pcm_mode) begin
						pcm_drive_d = item.level ? (8'd0 - {1'b0, cfg.out_volume})
							: {1'b0, cfg.out_volume};
					end else if (cfg.save_mode && item.level) begin
						last_edge_d = clock_count_q;
						if (gap >= GAP_MIN && gap < GAP_ONE) begin
							if (pack_count_q == 3'd7) begin
								if (!cfg.write_protect) begin
									res.write_valid = 1'b1;
									res.write_byte  = merged_bits;
								end
								pack_bits_d  = 8'd0;
								pack_count_d = 3'd0;
							end else begin
								pack_bits_d  = merged_bits;
								pack_count_d = pack_count_q + 3'd1;
							end
						end
					end
				end
			end
			ACT_MOTOR: begin
				if (item.level != motor_q) begin
					motor_d     = item.level;
					motor_clear = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (motor_clear) begin
			rate_rem_d     = '0;
			last_edge_d    = clock_count_q;
			half_left_d    = '0;
			pcm_drive_d    = '0;
			pack_count_d   = '0;
			pack_bits_d    = '0;
			unpack_count_d = '0;
			unpack_bits_d  = '0;
			cur_bit_d      = 1'b0;
			tap_a_d        = '0;
			tap_b_d        = '0;
		end

		res.input_level = in_level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_count_q  <= '0;
			last_edge_q    <= '0;
			half_left_q    <= '0;
			rate_rem_q     <= '0;
			motor_q        <= 1'b0;
			out_level_q    <= 1'b0;
			in_level_q     <= 1'b0;
			pcm_drive_q    <= '0;
			pack_count_q   <= '0;
			pack_bits_q    <= '0;
			unpack_count_q <= '0;
			unpack_bits_q  <= '0;
			cur_bit_q      <= 1'b0;
			tap_a_q        <= '0;
			tap_b_q        <= '0;
		end else if (clear) begin
			last_edge_q    <= clock_count_q;
			half_left_q    <= '0;
			rate_rem_q     <= '0;
			pcm_drive_q    <= '0;
			pack_count_q   <= '0;
			pack_bits_q    <= '0;
			unpack_count_q <= '0;
			unpack_bits_q  <= '0;
			cur_bit_q      <= 1'b0;
			tap_a_q        <= '0;
			tap_b_q        <= '0;
		end else if (advance) begin
			clock_count_q  <= clock_count_d;
			last_edge_q    <= last_edge_d;
			half_left_q    <= half_left_d;
			rate_rem_q     <= rate_rem_d;
			motor_q        <= motor_d;
			out_level_q    <= out_level_d;
			in_level_q     <= in_level_d;
			pcm_drive_q    <= pcm_drive_d;
			pack_count_q   <= pack_count_d;
			pack_bits_q    <= pack_bits_d;
			unpack_count_q <= unpack_count_d;
			unpack_bits_q  <= unpack_bits_d;
			cur_bit_q      <= cur_bit_d;
			tap_a_q        <= tap_a_d;
			tap_b_q        <= tap_b_d;
		end
	end

endmodule

// ===== rtl/core/cassette_tape_modem_unit.sv =====
// ----------------------------------------------------------------------------
// cassette_tape_modem_unit: cassette port modem, top level
// Turns clock-tick, output-level and motor events into tape bytes on save and
// into a cassette input level on load, in pulse-width bit or PCM format.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  -----------------------------------
//  event     in         in_valid / in_ready  action tick_count level tape_byte
//                                            tape_byte_ok
//  result    out        out_valid/out_ready  input_level byte_taken write_valid
//                                            write_byte
//  config    in         cfg_we (no wait)     cfg_index cfg_data
//
// One event per clock sustained while out_ready stays high. An event is captured
// in the input stage at its transfer and processed from there; the result
// register loads when the engine processes the event and offers the result
// on the result channel. The state update is one pass of logic, so
// back-to-back events never wait on each other; only a stalled result
// register holds the input stage. Reset clears the engine state and the valid
// flags and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cassette_tape_modem_unit
	import ctm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// event channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [3:0]            tick_count,
	input  logic                  level,
	input  logic [7:0]            tape_byte,
	input  logic                  tape_byte_ok,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  input_level,
	output logic                  byte_taken,
	output logic                  write_valid,
	output logic [7:0]            write_byte,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;
	logic    clear;

	// Process the staged event whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Mode and rate writes restart the running state; save_mode only on change
	assign clear = cfg_we && ((cfg_index == CFG_PCM_MODE) || (cfg_index == CFG_SAMPLE_RATE)
		|| ((cfg_index == CFG_SAVE_MODE) && (cfg_data[0] != cfg_q.save_mode)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.save_mode     <= 1'b0;
			cfg_q.pcm_mode      <= 1'b0;
			cfg_q.sample_rate   <= RATE_RESET;
			cfg_q.write_protect <= 1'b0;
			cfg_q.out_volume    <= VOLUME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAVE_MODE:     cfg_q.save_mode     <= cfg_data[0];
				CFG_PCM_MODE:      cfg_q.pcm_mode      <= cfg_data[0];
				CFG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg_data[16:0];
				CFG_WRITE_PROTECT: cfg_q.write_protect <= cfg_data[0];
				CFG_OUT_VOLUME:    cfg_q.out_volume    <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: hold the event until the engine takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action: action, tick_count: tick_count, level: level,
				tape_byte: tape_byte, tape_byte_ok: tape_byte_ok};
		end
	end

	ctm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.clear   (clear),
		.cfg     (cfg_q),
		.item    (item_s1),
		.res     (res)
	);

	// Result register: load on advance, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign input_level = result_q.input_level;
	assign byte_taken  = result_q.byte_taken;
	assign write_valid = result_q.write_valid;
	assign write_byte  = result_q.write_byte;

`ifndef NO_ASSERTIONS
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed event did not reach the result register");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.write_valid) |-> (result_q.write_byte == 8'd0))
		else $error("write byte not zero without a write");

	a_read_or_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.byte_taken && result_q.write_valid))
		else $error("one event both read and wrote the tape");
`endif

endmodule

// ===== test/cassette_tape_modem_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cassette_tape_modem_unit_tb: self-checking bench for the cassette tape modem
// Feeds tick, output-level and motor events through the valid/ready event
// channel and compares every result against a cycle-free behavioral predictor.
// Covers bit load, bit save with and without write protect, PCM save and PCM
// load over several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module cassette_tape_modem_unit_tb;
	import ctm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Event code with no meaning to the modem, and a register index it ignores
	localparam logic [1:0]           ACT_NONE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
	localparam int unsigned          QUIET_LIMIT = 2000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [1:0]            action       = '0;
	logic [3:0]            tick_count   = '0;
	logic                  level        = 1'b0;
	logic [7:0]            tape_byte    = '0;
	logic                  tape_byte_ok = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  input_level;
	logic                  byte_taken;
	logic                  write_valid;
	logic [7:0]            write_byte;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	cassette_tape_modem_unit dut (.*);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: a mirror of the modem's registers and running state
	// ------------------------------------------------------------------------
	logic              set_save = 1'b0;
	logic              set_pcm  = 1'b0;
	logic [16:0]       set_rate = RATE_RESET;
	logic              set_wp   = 1'b0;
	logic [6:0]        set_vol  = VOLUME_RESET;

	logic [31:0]       ticks_total  = '0;  // free-running tape clock, wraps
	logic [31:0]       last_rise    = '0;  // tape clock at last rising output edge
	logic [9:0]        half_left    = '0;  // clocks left in current load half-period
	logic [20:0]       rate_frac    = '0;  // sample-rate accumulator remainder
	logic              motor        = 1'b0;
	logic              drv_level    = 1'b0;  // cassette output level
	logic              rx_level     = 1'b0;  // cassette input level
	logic [7:0]        drive_sample = '0;
	logic [3:0]        pack_n       = '0;
	logic [7:0]        pack_reg     = '0;
	logic [3:0]        unpack_n     = '0;
	logic [7:0]        unpack_reg   = '0;
	logic              bit_now      = 1'b0;
	logic signed [7:0] taps [3]     = '{default: '0};

	item_t       tape_events [$];   // events waiting for the driver
	result_t     due_results [$];   // predicted results, oldest first
	item_t       on_wire;           // event currently offered on the channel
	int unsigned mismatches   = 0;
	int unsigned send_gap     = 0;
	int unsigned send_calm    = 0;
	int unsigned recv_stall   = 0;
	int unsigned recv_calm    = 0;
	int unsigned quiet_cycles = 0;

	// Drop everything a mode or motor change restarts; keep levels and time.
	function automatic void clear_running();
		rate_frac    = '0;
		last_rise    = ticks_total;
		half_left    = '0;
		drive_sample = '0;
		pack_n       = '0;
		pack_reg     = '0;
		unpack_n     = '0;
		unpack_reg   = '0;
		bit_now      = 1'b0;
		taps[0]      = '0;
		taps[1]      = '0;
		taps[2]      = '0;
	endfunction

	// Advance the mirror by one event and return the result it produces.
	function automatic result_t cassette_result(item_t ev);
		result_t     res;
		int unsigned samples, rest, gap;
		int          smooth;
		logic        took, wr, have;
		logic [7:0]  wbyte;
		took  = 1'b0;
		wr    = 1'b0;
		wbyte = 8'h00;
		have  = 1'b1;
		case (ev.action)
			ACT_TICKS: begin
				ticks_total = ticks_total + 32'(ev.tick_count);
				if (motor && set_pcm) begin
					samples   = set_rate * ev.tick_count + rate_frac;
					rate_frac = 21'(samples % TAPE_CLK_1);
					samples   = samples / TAPE_CLK_1;
					// several instants in one event still give one sample
					if (samples != 0) begin
						if (set_save) begin
							if (!set_wp) begin
								wr    = 1'b1;
								wbyte = drive_sample;
							end
						end else if (ev.tape_byte_ok) begin
							took    = 1'b1;
							taps[0] = taps[1];
							taps[1] = taps[2];
							taps[2] = ev.tape_byte;
							// [1 2 1]/4, truncated toward zero
							smooth   = (taps[0] + 2 * taps[1] + taps[2]) / 4;
							rx_level = (smooth >= 0);
						end else begin
							// end of tape reads as a zero sample
							rx_level = 1'b1;
						end
					end
				end else if (motor && !set_save) begin
					if (half_left > ev.tick_count) begin
						half_left = half_left - 10'(ev.tick_count);
					end else begin
						rest     = 32'(ev.tick_count) - 32'(half_left);
						rx_level = ~rx_level;
						if (rx_level) begin
							if (unpack_n == 0) begin
								if (ev.tape_byte_ok) begin
									took       = 1'b1;
									unpack_n   = 4'd8;
									unpack_reg = ev.tape_byte;
								end else begin
									// end of tape: repeat the previous bit
									have = 1'b0;
								end
							end
							if (have) begin
								bit_now    = unpack_reg[7];
								unpack_reg = unpack_reg << 1;
								unpack_n   = unpack_n - 4'd1;
							end
						end
						half_left = bit_now ? HALF_ONE : HALF_ZERO;
						if (32'(half_left) > rest)
							half_left = half_left - 10'(rest);
					end
				end
			end
			ACT_LEVEL: begin
				if (!motor) begin
					rx_level = ev.level;
				end else if (drv_level != ev.level) begin
					drv_level = ev.level;
					if (set_pcm) begin
						drive_sample = ev.level ? 8'(-{1'b0, set_vol}) : {1'b0, set_vol};
					end else if (set_save && ev.level) begin
						gap       = ticks_total - last_rise;
						last_rise = ticks_total;
						if (gap >= GAP_MIN && gap < GAP_ONE) begin
							if (gap >= GAP_ZERO && !set_wp)
								pack_reg = pack_reg | (8'h80 >> pack_n[2:0]);
							pack_n = pack_n + 4'd1;
							if (pack_n >= 4'd8) begin
								if (!set_wp) begin
									wr    = 1'b1;
									wbyte = pack_reg;
								end
								pack_reg = '0;
								pack_n   = '0;
							end
						end
					end
				end
			end
			ACT_MOTOR: begin
				if (ev.level != motor) begin
					motor = ev.level;
					clear_running();
				end
			end
			default: ;
		endcase
		res.input_level = rx_level;
		res.byte_taken  = took;
		res.write_valid = wr;
		res.write_byte  = wbyte;
		return res;
	endfunction

	// Gap before the next transfer: mostly none, some short, a few long,
	// with occasional stretches of back-to-back traffic.
	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 2) begin
			calm = $urandom_range(60, 250);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Event driver: hold valid and payload until transfer, then predict
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic  hold;
		item_t nxt;
		hold = in_valid;
		if (in_valid && in_ready) begin
			due_results.push_back(cassette_result(on_wire));
			hold = 1'b0;
		end
		if (!hold && arst_n) begin
			if (send_gap != 0) begin
				send_gap--;
			end else if (tape_events.size() != 0) begin
				nxt          = tape_events.pop_front();
				on_wire      = nxt;
				action       <= nxt.action;
				tick_count   <= nxt.tick_count;
				level        <= nxt.level;
				tape_byte    <= nxt.tape_byte;
				tape_byte_ok <= nxt.tape_byte_ok;
				hold         = 1'b1;
				send_gap     = next_gap(send_calm);
			end
		end
		in_valid <= hold;
	end

	// ------------------------------------------------------------------------
	// Result monitor: check each transfer against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t got, want;
		logic    rdy;
		if (out_valid && out_ready) begin
			got = {input_level, byte_taken, write_valid, write_byte};
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result level=%0d taken=%0d wvalid=%0d wbyte=%02h",
						$time, got.input_level, got.byte_taken, got.write_valid,
						got.write_byte);
			end else begin
				want = due_results.pop_front();
				if (got.input_level !== want.input_level || got.byte_taken !== want.byte_taken
						|| got.write_valid !== want.write_valid
						|| got.write_byte !== want.write_byte) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch expected level=%0d taken=%0d wvalid=%0d ",
							"wbyte=%02h, got level=%0d taken=%0d wvalid=%0d wbyte=%02h"},
							$time, want.input_level, want.byte_taken, want.write_valid,
							want.write_byte, got.input_level, got.byte_taken,
							got.write_valid, got.write_byte);
				end
			end
			recv_stall = next_gap(recv_calm);
		end
		// stall after a transfer, otherwise keep accepting
		if (recv_stall != 0) begin
			recv_stall--;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		out_ready <= rdy;
	end

	// Watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic add(input int unsigned act, input int unsigned ticks,
			input int unsigned lvl, input int unsigned tb, input int unsigned ok);
		tape_events.push_back({2'(act), 4'(ticks), 1'(lvl), 8'(tb), 1'(ok)});
	endtask

	// Write one register; the block is idle whenever this runs.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		case (idx)
			CFG_SAVE_MODE: begin
				if (val[0] != set_save) begin
					set_save = val[0];
					clear_running();
				end
			end
			CFG_PCM_MODE: begin
				set_pcm = val[0];
				clear_running();
			end
			CFG_SAMPLE_RATE: begin
				set_rate = 17'(val);
				clear_running();
			end
			CFG_WRITE_PROTECT: set_wp  = val[0];
			CFG_OUT_VOLUME:    set_vol = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every event is through and every result is back, plus the
	// pipeline depth. Sampled on the falling edge to stay clear of updates.
	task automatic settle();
		do
			@(negedge clk);
		while (tape_events.size() != 0 || in_valid || due_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// Mostly tick batches, with output level changes, short motor-off
	// excursions and unknown events mixed in.
	task automatic mixed_run(input int unsigned count, input int unsigned level_pct);
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < level_pct) begin
				add(ACT_LEVEL, $urandom_range(15), $urandom_range(1), $urandom_range(255),
					$urandom_range(1));
			end else if (r < level_pct + 1) begin
				add(ACT_MOTOR, $urandom_range(15), 1'b0, $urandom_range(255), $urandom_range(1));
				repeat ($urandom_range(1, 4))
					add($urandom_range(1) ? ACT_LEVEL : ACT_TICKS, $urandom_range(15),
						$urandom_range(1), $urandom_range(255), $urandom_range(1));
				add(ACT_MOTOR, $urandom_range(15), 1'b1, $urandom_range(255), $urandom_range(1));
			end else if (r < level_pct + 2) begin
				add(ACT_NONE, $urandom_range(15), $urandom_range(1), $urandom_range(255),
					$urandom_range(1));
			end else begin
				add(ACT_TICKS, ($urandom_range(9) < 7) ? $urandom_range(8, 15) : $urandom_range(7),
					$urandom_range(1), $urandom_range(255), ($urandom_range(9) != 0));
			end
		end
	endtask

	// Well-formed save traffic: drop the output, let a chosen number of
	// clocks pass, raise it again. Gap lengths cover every class and land
	// exactly on the class boundaries now and then.
	task automatic save_bits(input int unsigned nbits);
		int unsigned done, target, acc, t, k;
		done = 0;
		while (done < nbits) begin
			case ($urandom_range(19))
				0, 1: target = $urandom_range(40, 297);
				2:    target = $urandom_range(1491, 1700);
				3, 4, 5, 6: begin
					k      = $urandom_range(2);
					target = (k == 0) ? GAP_MIN : (k == 1) ? GAP_ZERO : GAP_ONE;
					target = target - $urandom_range(1);
				end
				7, 8, 9, 10, 11, 12: target = $urandom_range(298, 893);
				default: target = $urandom_range(894, 1490);
			endcase
			add(ACT_LEVEL, $urandom_range(15), 1'b0, $urandom_range(255), $urandom_range(1));
			acc = 0;
			while (acc < target) begin
				case ($urandom_range(49))
					0: add(ACT_NONE, $urandom_range(15), $urandom_range(1), $urandom_range(255),
						$urandom_range(1));
					1: add(ACT_LEVEL, $urandom_range(15), 1'b0, $urandom_range(255),
						$urandom_range(1));
					2: add(ACT_TICKS, 4'd0, $urandom_range(1), $urandom_range(255),
						$urandom_range(1));
					default: ;
				endcase
				t = $urandom_range(12, 15);
				if (t > target - acc)
					t = target - acc;
				add(ACT_TICKS, t, $urandom_range(1), $urandom_range(255), $urandom_range(1));
				acc += t;
			end
			add(ACT_LEVEL, $urandom_range(15), 1'b1, $urandom_range(255), $urandom_range(1));
			if (target >= GAP_MIN && target < GAP_ONE)
				done++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: bit-format load. Motor off passes levels straight
		// through and lets ticks only advance time.
		add(ACT_LEVEL, 4'd0, 1'b1, 8'h00, 1'b0);
		add(ACT_LEVEL, 4'd15, 1'b0, 8'hFF, 1'b1);
		add(ACT_NONE, 4'd15, 1'b1, 8'hFF, 1'b1);
		add(ACT_MOTOR, 4'd0, 1'b0, 8'h00, 1'b0);   // motor already off
		add(ACT_TICKS, 4'd15, 1'b0, 8'h5A, 1'b1);
		add(ACT_MOTOR, 4'd0, 1'b1, 8'h00, 1'b0);
		add(ACT_MOTOR, 4'd0, 1'b1, 8'h00, 1'b0);   // motor already on
		add(ACT_TICKS, 4'd0, 1'b0, 8'hA5, 1'b1);   // empty half-period expires
		add(ACT_TICKS, 4'd15, 1'b1, 8'hFF, 1'b0);
		add(ACT_LEVEL, 4'd8, 1'b1, 8'h00, 1'b0);   // output level unused on load
		add(ACT_LEVEL, 4'd8, 1'b1, 8'h00, 1'b0);
		mixed_run(150, 3);
		settle();

		// Bit save: second save_mode write is no change and keeps state
		write_reg(CFG_SAVE_MODE, 1);
		write_reg(CFG_SAVE_MODE, 1);
		write_reg(CFG_WRITE_PROTECT, 0);
		save_bits(8);
		settle();
		write_reg(CFG_WRITE_PROTECT, 1);
		save_bits(8);
		settle();

		// PCM save at full volume, then silent and protected, then random
		write_reg(CFG_PCM_MODE, 1);
		write_reg(CFG_SAMPLE_RATE, 96000);
		write_reg(CFG_OUT_VOLUME, 127);
		write_reg(CFG_WRITE_PROTECT, 0);
		add(ACT_LEVEL, 4'd0, 1'b1, 8'h00, 1'b0);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h00, 1'b0);
		add(ACT_LEVEL, 4'd0, 1'b0, 8'h00, 1'b0);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h00, 1'b0);
		mixed_run(120, 30);
		settle();
		write_reg(CFG_OUT_VOLUME, 0);
		write_reg(CFG_WRITE_PROTECT, 1);
		write_reg(CFG_SAMPLE_RATE, 17'h1FFFF);
		mixed_run(60, 30);
		settle();
		write_reg(CFG_WRITE_PROTECT, 0);
		write_reg(CFG_OUT_VOLUME, $urandom_range(1, 126));
		write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 96000));
		mixed_run(60, 30);
		settle();

		// PCM load. At the top rate every 15-tick batch is a sample instant,
		// some of them double ones. Walk the filter through rounding toward
		// zero, the negative and positive extremes and end of tape.
		write_reg(CFG_SAVE_MODE, 0);
		write_reg(CFG_SAMPLE_RATE, 17'h1FFFF);
		add(ACT_TICKS, 4'd15, 1'b0, 8'hFD, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b0, 8'hFF, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b1, 8'h80, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b1, 8'h80, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b1, 8'h80, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h7F, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h7F, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h7F, 1'b1);
		add(ACT_TICKS, 4'd15, 1'b0, 8'h80, 1'b0);
		add(ACT_TICKS, 4'd0, 1'b0, 8'h80, 1'b1);
		mixed_run(60, 5);
		settle();
		write_reg(CFG_SAMPLE_RATE, 96000);
		mixed_run(60, 5);
		settle();
		write_reg(CFG_SAMPLE_RATE, 1);
		mixed_run(30, 5);
		settle();
		write_reg(CFG_SAMPLE_RATE, 0);
		mixed_run(30, 5);
		settle();
		write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 96000));
		mixed_run(80, 5);
		settle();

		// Back to bit load at reset values; a write to an unused index
		// must leave everything alone.
		write_reg(CFG_PCM_MODE, 0);
		write_reg(CFG_SAMPLE_RATE, RATE_RESET);
		write_reg(CFG_OUT_VOLUME, VOLUME_RESET);
		write_reg(CFG_UNUSED, $urandom_range(17'h1FFFF));
		mixed_run(100, 5);
		settle();

		if (mismatches == 0 && due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ctm_pkg.sv
rtl/core/ctm_rate.sv
rtl/core/ctm_engine.sv
rtl/core/cassette_tape_modem_unit.sv
test/cassette_tape_modem_unit_tb.sv
